@@ design/csfb_pkg.sv @@
// Package for the clipped span fill unit: types, codes and fixed field widths
`timescale 1ns / 1ps

package csfb_pkg;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int COORD_W    = 16;
    localparam int PIX_W      = 8;
    localparam int ADDR_IN_W  = 18;
    localparam int DIM_W      = 11;
    localparam int BASE_W     = 18;
    localparam int BLEND_W    = 2;
    localparam int TBL_AW     = 16;
    localparam int TBL_DEPTH  = 65536;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TABLE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 3'd4;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 11'd480;
    localparam logic [DIM_W-1:0]   RST_STRIDE = 11'd640;
    localparam logic [BASE_W-1:0]  RST_BASE   = 18'd0;
    localparam logic [BLEND_W-1:0] RST_BLEND  = 2'd0;

    // result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   stride;
        logic [BASE_W-1:0]  base;
        logic [BLEND_W-1:0] blend;
    } cfg_regs_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [PIX_W-1:0]         pen_colour;
        logic [ADDR_IN_W-1:0]     target_address;
        logic [PIX_W-1:0]         write_value;
    } item_t;

    typedef struct packed {
        logic             status;
        logic [PIX_W-1:0] read_value;
    } result_t;

    typedef struct packed {
        logic frame_rd;
        logic frame_wr;
        logic table_rd;
        logic table_wr;
    } mem_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SUM,
        ST_ADDR,
        ST_STEP,
        ST_PIX_RD,
        ST_PIX_OLD,
        ST_PIX_BLEND,
        ST_RD_DATA,
        ST_TBL,
        ST_DONE
    } state_t;

endpackage

@@ design/csfb_store.sv @@
// Framebuffer and translucency table memories with registered reads
`timescale 1ns / 1ps

module csfb_store
    import csfb_pkg::*;
#(
    parameter int FRAME_DEPTH = 262144
)
(
    input  logic                           clk,
    input  mem_ctl_t                       ctl,
    input  logic [$clog2(FRAME_DEPTH)-1:0] frame_addr,
    input  logic [PIX_W-1:0]               frame_wdata,
    output logic [PIX_W-1:0]               frame_rdata,
    input  logic [TBL_AW-1:0]              table_raddr,
    input  logic [TBL_AW-1:0]              table_waddr,
    input  logic [PIX_W-1:0]               table_wdata,
    output logic [PIX_W-1:0]               table_rdata
);

    logic [PIX_W-1:0] frame_mem [FRAME_DEPTH];
    logic [PIX_W-1:0] table_mem [TBL_DEPTH];
    logic [PIX_W-1:0] frame_rdata_reg;
    logic [PIX_W-1:0] table_rdata_reg;

    // framebuffer port, read or write at one address
    always_ff @(posedge clk)
    begin
        if (ctl.frame_wr)
        begin
            frame_mem[frame_addr] <= frame_wdata;
        end
        if (ctl.frame_rd)
        begin
            frame_rdata_reg <= frame_mem[frame_addr];
        end
    end

    // table, separate read and write addresses
    always_ff @(posedge clk)
    begin
        if (ctl.table_wr)
        begin
            table_mem[table_waddr] <= table_wdata;
        end
        if (ctl.table_rd)
        begin
            table_rdata_reg <= table_mem[table_raddr];
        end
    end

    assign frame_rdata = frame_rdata_reg;
    assign table_rdata = table_rdata_reg;

endmodule

@@ design/csfb_mod.sv @@
// Address reduction unit: value modulo the framebuffer depth by reciprocal multiplication
`timescale 1ns / 1ps

module csfb_mod
    import csfb_pkg::*;
#(
    parameter int FRAME_DEPTH = 262144,
    parameter int VAL_W       = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [VAL_W-1:0]               value,
    output logic                           done,
    output logic [$clog2(FRAME_DEPTH)-1:0] result
);

    localparam int     AW    = $clog2(FRAME_DEPTH);
    localparam int     QW    = VAL_W - AW + 2;
    localparam int     RW    = AW + 1;
    localparam int     PRW   = VAL_W + QW;
    localparam longint RECIP = (longint'(1) << VAL_W) / longint'(FRAME_DEPTH);

    logic [VAL_W-1:0] val_reg;
    logic [QW-1:0]    quot_reg;
    logic [RW-1:0]    rem_reg;
    logic [2:0]       stage_reg;
    logic [PRW-1:0]   prod;
    logic [VAL_W-1:0] back;
    logic [VAL_W-1:0] diff;

    // quotient estimate, at most one below the true quotient
    assign prod = PRW'(val_reg) * PRW'(RECIP);

    // remainder before the final correction, below twice the depth
    assign back = VAL_W'(quot_reg) * VAL_W'(FRAME_DEPTH);
    assign diff = val_reg - back;

    // stage valid bits, start shifts through the stage register to done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], start};
        end
    end

    // pipeline data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
        end
        if (stage_reg[0])
        begin
            quot_reg <= prod[PRW-1:VAL_W];
        end
        if (stage_reg[1])
        begin
            rem_reg <= diff[RW-1:0];
        end
    end

    // one conditional subtract finishes the reduction
    assign done   = stage_reg[2];
    assign result = (rem_reg >= RW'(FRAME_DEPTH)) ? AW'(rem_reg - RW'(FRAME_DEPTH))
                                                   : rem_reg[AW-1:0];

endmodule

@@ design/csfb_ctrl.sv @@
// Sequencer: clipping, address setup and the read-modify-write pixel walk
`timescale 1ns / 1ps

module csfb_ctrl
    import csfb_pkg::*;
#(
    parameter int FRAME_DEPTH = 262144,
    parameter int MAX_DIM     = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_regs_t                      cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  item_t                          item,
    output logic                           res_valid,
    input  logic                           res_take,
    output result_t                        res,
    output mem_ctl_t                       mem_ctl,
    output logic [$clog2(FRAME_DEPTH)-1:0] frame_addr,
    output logic [PIX_W-1:0]               frame_wdata,
    input  logic [PIX_W-1:0]               frame_rdata,
    output logic [TBL_AW-1:0]              table_raddr,
    output logic [TBL_AW-1:0]              table_waddr,
    output logic [PIX_W-1:0]               table_wdata,
    input  logic [PIX_W-1:0]               table_rdata
);

    localparam int AW    = $clog2(FRAME_DEPTH);
    localparam int XW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int PW    = DIM_W + XW;
    localparam int MW0   = (PW > BASE_W) ? PW : BASE_W;
    localparam int MW1   = (MW0 > AW) ? MW0 : AW;
    localparam int VAL_W = MW1 + 1;

    state_t              state_reg;
    state_t              state_next;
    item_t               item_reg;
    logic [XW-1:0]       x0_reg;
    logic [PW-1:0]       prod_reg;
    logic                vert_reg;
    logic [CW-1:0]       count_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       step_reg;
    logic                status_reg;
    logic [PIX_W-1:0]    rval_reg;

    logic                in_accept;
    logic                mod_start;
    logic [VAL_W-1:0]    mod_value;
    logic                mod_done;
    logic [AW-1:0]       mod_result;
    logic                last_pix;
    logic [AW:0]         addr_sum;
    logic [AW-1:0]       addr_step;

    logic [16:0]         lim_x;
    logic [16:0]         lim_y;
    logic signed [16:0]  top_x;
    logic signed [16:0]  top_y;
    logic signed [16:0]  xa;
    logic signed [16:0]  xb;
    logic signed [16:0]  ya;
    logic signed [16:0]  yb;
    logic signed [16:0]  xl;
    logic signed [16:0]  xh;
    logic signed [16:0]  yl;
    logic signed [16:0]  yh;
    logic                reject;
    logic [XW-1:0]       clip_x0;
    logic [XW-1:0]       clip_x1;
    logic [XW-1:0]       clip_y0;
    logic [XW-1:0]       clip_y1;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign last_pix  = (count_reg == CW'(1));

    // next address along the run, wrapped into the framebuffer
    assign addr_sum  = {1'b0, addr_reg} + {1'b0, step_reg};
    assign addr_step = (addr_sum >= (AW + 1)'(FRAME_DEPTH))
                       ? AW'(addr_sum - (AW + 1)'(FRAME_DEPTH)) : addr_sum[AW-1:0];

    // order and clamp both coordinate pairs to the window
    always_comb
    begin
        lim_x = (17'(cfg.width) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(cfg.width);
        lim_y = (17'(cfg.height) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(cfg.height);
        top_x = $signed(lim_x - 17'd1);
        top_y = $signed(lim_y - 17'd1);
        xa = {item_reg.first_x[COORD_W-1], item_reg.first_x};
        xb = {item_reg.second_x[COORD_W-1], item_reg.second_x};
        ya = {item_reg.first_y[COORD_W-1], item_reg.first_y};
        yb = {item_reg.second_y[COORD_W-1], item_reg.second_y};
        xl = (xa < xb) ? xa : xb;
        xh = (xa < xb) ? xb : xa;
        yl = (ya < yb) ? ya : yb;
        yh = (ya < yb) ? yb : ya;
        reject = (lim_x == 17'd0) || (xh < 17'sd0) || (xl > top_x)
              || (lim_y == 17'd0) || (yh < 17'sd0) || (yl > top_y);
        clip_x0 = (xl < 17'sd0) ? '0 : xl[XW-1:0];
        clip_x1 = (xh > top_x) ? top_x[XW-1:0] : xh[XW-1:0];
        clip_y0 = (yl < 17'sd0) ? '0 : yl[XW-1:0];
        clip_y1 = (yh > top_y) ? top_y[XW-1:0] : yh[XW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (item.kind)
                        KIND_DRAW:  state_next = ST_CLIP;
                        KIND_TABLE: state_next = ST_TBL;
                        default:    state_next = ST_ADDR;
                    endcase
                end
            end
            ST_CLIP:
            begin
                state_next = reject ? ST_DONE : ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (mod_done)
                begin
                    case (item_reg.kind)
                        KIND_DRAW:  state_next = vert_reg ? ST_STEP : ST_PIX_RD;
                        KIND_READ:  state_next = ST_RD_DATA;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_STEP:
            begin
                if (mod_done)
                begin
                    state_next = ST_PIX_RD;
                end
            end
            ST_PIX_RD:
            begin
                state_next = ST_PIX_OLD;
            end
            ST_PIX_OLD:
            begin
                if (cfg.blend != '0)
                begin
                    state_next = ST_PIX_BLEND;
                end
                else
                begin
                    state_next = last_pix ? ST_DONE : ST_PIX_RD;
                end
            end
            ST_PIX_BLEND:
            begin
                state_next = last_pix ? ST_DONE : ST_PIX_RD;
            end
            ST_RD_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_TBL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory and reduction unit controls
    always_comb
    begin
        mem_ctl     = '0;
        frame_addr  = addr_reg;
        frame_wdata = item_reg.pen_colour;
        table_raddr = {item_reg.pen_colour, frame_rdata};
        table_waddr = item_reg.target_address[TBL_AW-1:0];
        table_wdata = item_reg.write_value;
        mod_start   = 1'b0;
        mod_value   = VAL_W'(item.target_address);
        res_valid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mod_start = in_accept && (item.kind == KIND_WRITE || item.kind == KIND_READ);
            end
            ST_SUM:
            begin
                mod_start = 1'b1;
                mod_value = VAL_W'(cfg.base) + VAL_W'(x0_reg) + VAL_W'(prod_reg);
            end
            ST_ADDR:
            begin
                frame_addr  = mod_result;
                frame_wdata = item_reg.write_value;
                if (mod_done)
                begin
                    case (item_reg.kind)
                        KIND_DRAW:
                        begin
                            mod_start = vert_reg;
                            mod_value = VAL_W'(cfg.stride);
                        end
                        KIND_WRITE: mem_ctl.frame_wr = 1'b1;
                        KIND_READ:  mem_ctl.frame_rd = 1'b1;
                        default:    mem_ctl = '0;
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                mem_ctl.frame_rd = 1'b1;
            end
            ST_PIX_OLD:
            begin
                // colour-major blend wins over pixel-major
                if (cfg.blend[0])
                begin
                    mem_ctl.table_rd = 1'b1;
                    table_raddr      = {item_reg.pen_colour, frame_rdata};
                end
                else if (cfg.blend[1])
                begin
                    mem_ctl.table_rd = 1'b1;
                    table_raddr      = {frame_rdata, item_reg.pen_colour};
                end
                else
                begin
                    mem_ctl.frame_wr = 1'b1;
                end
            end
            ST_PIX_BLEND:
            begin
                mem_ctl.frame_wr = 1'b1;
                frame_wdata      = table_rdata;
            end
            ST_TBL:
            begin
                mem_ctl.table_wr = 1'b1;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_reg   <= item;
                    status_reg <= STATUS_OK;
                    rval_reg   <= '0;
                end
            end
            ST_CLIP:
            begin
                status_reg <= reject ? STATUS_REJECT : STATUS_OK;
                x0_reg     <= clip_x0;
                prod_reg   <= PW'(cfg.stride) * PW'(clip_y0);
                vert_reg   <= (clip_x0 == clip_x1);
                count_reg  <= (clip_x0 == clip_x1)
                              ? (CW'(clip_y1) - CW'(clip_y0) + CW'(1))
                              : (CW'(clip_x1) - CW'(clip_x0) + CW'(1));
            end
            ST_ADDR:
            begin
                if (mod_done)
                begin
                    addr_reg <= mod_result;
                    step_reg <= AW'(1);
                end
            end
            ST_STEP:
            begin
                if (mod_done)
                begin
                    step_reg <= mod_result;
                end
            end
            ST_PIX_OLD:
            begin
                if (cfg.blend == '0)
                begin
                    count_reg <= count_reg - CW'(1);
                    addr_reg  <= addr_step;
                end
            end
            ST_PIX_BLEND:
            begin
                count_reg <= count_reg - CW'(1);
                addr_reg  <= addr_step;
            end
            ST_RD_DATA:
            begin
                rval_reg <= frame_rdata;
            end
            default:
            begin
                rval_reg <= rval_reg;
            end
        endcase
    end

    assign res.status     = status_reg;
    assign res.read_value = rval_reg;

    csfb_mod #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .VAL_W       (VAL_W)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .value  (mod_value),
        .done   (mod_done),
        .result (mod_result)
    );

endmodule

@@ design/clipped_span_fill_with_blend.sv @@
// Top level of the clipped span fill unit with translucency blending
// From accept to result: a table write stores its entry; a pixel write or read reduces
// its address, then accesses the framebuffer; a rejected draw ends after clipping.
// A draw clips, sums and reduces its start address (a column also reduces the stride),
// then per pixel: framebuffer read, table read if blended, framebuffer write.
// One item in flight; the next is accepted the cycle after its result is handed over.
// Reset: registers to 640, 480, 640, 0, 0; memories are not cleared.
`timescale 1ns / 1ps

module clipped_span_fill_with_blend
    import csfb_pkg::*;
#(
    parameter int FRAME_DEPTH = 262144,
    parameter int MAX_DIM     = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_x, first_y, second_x, second_y, pen_colour, target_address,
    // write_value, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, read_value, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_regs_t          cfg_reg;
    item_t              item;
    result_t            res;
    logic               res_valid;
    logic               res_take;
    logic               m_valid_reg;
    result_t            m_res_reg;
    mem_ctl_t           mem_ctl;
    logic [$clog2(FRAME_DEPTH)-1:0] frame_addr;
    logic [PIX_W-1:0]   frame_wdata;
    logic [PIX_W-1:0]   frame_rdata;
    logic [TBL_AW-1:0]  table_raddr;
    logic [TBL_AW-1:0]  table_waddr;
    logic [PIX_W-1:0]   table_wdata;
    logic [PIX_W-1:0]   table_rdata;

    // unpack input item
    assign item.kind           = s_tuser;
    assign item.first_x        = s_tdata[15:0];
    assign item.first_y        = s_tdata[31:16];
    assign item.second_x       = s_tdata[47:32];
    assign item.second_y       = s_tdata[63:48];
    assign item.pen_colour     = s_tdata[71:64];
    assign item.target_address = s_tdata[89:72];
    assign item.write_value    = s_tdata[97:90];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= RST_WIDTH;
            cfg_reg.height <= RST_HEIGHT;
            cfg_reg.stride <= RST_STRIDE;
            cfg_reg.base   <= RST_BASE;
            cfg_reg.blend  <= RST_BLEND;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  cfg_reg.width  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: cfg_reg.height <= cfg_data[DIM_W-1:0];
                REG_STRIDE: cfg_reg.stride <= cfg_data[DIM_W-1:0];
                REG_BASE:   cfg_reg.base   <= cfg_data[BASE_W-1:0];
                REG_BLEND:  cfg_reg.blend  <= cfg_data[BLEND_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // output register
    assign res_take = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({m_res_reg.read_value, m_res_reg.status});

    csfb_ctrl #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .item        (item),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .frame_addr  (frame_addr),
        .frame_wdata (frame_wdata),
        .frame_rdata (frame_rdata),
        .table_raddr (table_raddr),
        .table_waddr (table_waddr),
        .table_wdata (table_wdata),
        .table_rdata (table_rdata)
    );

    csfb_store #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk         (clk),
        .ctl         (mem_ctl),
        .frame_addr  (frame_addr),
        .frame_wdata (frame_wdata),
        .frame_rdata (frame_rdata),
        .table_raddr (table_raddr),
        .table_waddr (table_waddr),
        .table_wdata (table_wdata),
        .table_rdata (table_rdata)
    );

endmodule

@@ design/csfb_checker.sv @@
// Port-level checker for the clipped span fill unit, bound to the top level
`timescale 1ns / 1ps

module csfb_checker
    import csfb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // an accepted item makes the unit busy, so input ready is low in the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // fill bits above read_value are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:9] == '0))
        else $error("nonzero fill bits in result");

    // a rejected draw never carries read data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[8:1] == '0))
        else $error("rejected result with read data");

endmodule

bind clipped_span_fill_with_blend csfb_checker u_csfb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
